// File: design/ufe_pkg.sv
// Shared types and constants for the union-find engine.
`timescale 1ns / 1ps
`default_nettype none
package ufe_pkg;

	localparam int NODES_DEF = 256;
	localparam logic [3:0] RANK_MAX = 4'd15;

	localparam logic FUNC_FIND  = 1'b0;
	localparam logic FUNC_UNION = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_URA,
		ST_URB
	} ufe_state_t;

endpackage
`default_nettype wire

// File: design/union_find_engine_unit.sv
// Union-find engine: parent and rank tables in synchronous RAM, union by rank, path compression.
// One item at a time, busy high. Out-of-range items and self-unions finish from idle; a union
// of two roots reads both ranks, then links them; a find on a path of L links makes L + 1 parent
// reads, L rewrites and a final check at the root; a looping path ends after NODES + 1 reads.
// Throughput is set by the single read port of the parent RAM: one link per cycle.
// After reset a clearing pass initializes both tables; busy is high meanwhile.
// done pulses for one cycle with root and was_union; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module union_find_engine_unit
	import ufe_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       func,
	input  wire logic [7:0] node_a,
	input  wire logic [7:0] node_b,
	output logic            done,
	output logic [7:0]      root,
	output logic            was_union
);

	localparam int IW = $clog2(NODES);
	localparam int SW = $clog2(NODES + 1);

	function automatic logic [7:0] low8(input logic [IW-1:0] x);
		logic [IW+7:0] w;
		w = {8'b0, x};
		return w[7:0];
	endfunction

	// tables
	logic [IW-1:0] parent_mem [NODES];
	logic [3:0]    rank_mem   [NODES];

	logic [IW-1:0] p_ra, p_wa, p_wd, p_rd;
	logic          p_we;
	logic [IW-1:0] r_ra, r_wa;
	logic [3:0]    r_wd, r_rd;
	logic          r_we;

	always_ff @(posedge clk) begin
		if (p_we)
			parent_mem[p_wa] <= p_wd;
		p_rd <= parent_mem[p_ra];
	end

	always_ff @(posedge clk) begin
		if (r_we)
			rank_mem[r_wa] <= r_wd;
		r_rd <= rank_mem[r_ra];
	end

	// control and datapath registers
	ufe_state_t    state_q, state_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] a_q, a_d;
	logic [IW-1:0] b_q, b_d;
	logic [IW-1:0] root_idx_q, root_idx_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [SW-1:0] step_q, step_d;
	logic [3:0]    ra_q, ra_d;
	logic          done_q, done_d;
	logic [7:0]    root_q, root_d;
	logic          wu_q, wu_d;

	logic [IW+7:0] a_ext, b_ext;
	logic [IW-1:0] a_idx, b_idx;
	logic          a_ok, b_ok;

	assign a_ext = {IW'(0), node_a};
	assign b_ext = {IW'(0), node_b};
	assign a_idx = a_ext[IW-1:0];
	assign b_idx = b_ext[IW-1:0];
	assign a_ok  = ({24'b0, node_a} < 32'(NODES));
	assign b_ok  = ({24'b0, node_b} < 32'(NODES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			cur_q      <= '0;
			a_q        <= '0;
			b_q        <= '0;
			root_idx_q <= '0;
			step_q     <= '0;
			ra_q       <= '0;
			root_q     <= '0;
			wu_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			done_q     <= done_d;
			cur_q      <= cur_d;
			a_q        <= a_d;
			b_q        <= b_d;
			root_idx_q <= root_idx_d;
			step_q     <= step_d;
			ra_q       <= ra_d;
			root_q     <= root_d;
			wu_q       <= wu_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		done_d     = 1'b0;
		cur_d      = cur_q;
		a_d        = a_q;
		b_d        = b_q;
		root_idx_d = root_idx_q;
		step_d     = step_q;
		ra_d       = ra_q;
		root_d     = root_q;
		wu_d       = wu_q;
		p_ra       = cur_q;
		p_we       = 1'b0;
		p_wa       = cur_q;
		p_wd       = root_idx_q;
		r_ra       = a_q;
		r_we       = 1'b0;
		r_wa       = b_q;
		r_wd       = ra_q;
		case (state_q)
			ST_CLEAR: begin
				p_we  = 1'b1;
				p_wa  = clr_q;
				p_wd  = clr_q;
				r_we  = 1'b1;
				r_wa  = clr_q;
				r_wd  = '0;
				clr_d = clr_q + 1'b1;
				if (clr_q == IW'(NODES - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					a_d  = a_idx;
					b_d  = b_idx;
					wu_d = func;
					if (func == FUNC_FIND) begin
						if (!a_ok) begin
							done_d = 1'b1;
							root_d = node_a;
						end else begin
							cur_d   = a_idx;
							p_ra    = a_idx;
							step_d  = '0;
							state_d = ST_WALK;
						end
					end else begin
						if (!a_ok || !b_ok) begin
							done_d = 1'b1;
							root_d = node_b;
						end else if (node_a == node_b) begin
							done_d = 1'b1;
							root_d = node_a;
						end else begin
							r_ra    = a_idx;
							state_d = ST_URA;
						end
					end
				end
			end
			ST_WALK: begin
				if (p_rd == cur_q) begin
					root_idx_d = cur_q;
					cur_d      = a_q;
					p_ra       = a_q;
					state_d    = ST_COMP;
				end else begin
					cur_d  = p_rd;
					step_d = step_q + 1'b1;
					p_ra   = p_rd;
					// looping links: give up without rewriting
					if (step_q == SW'(NODES)) begin
						done_d  = 1'b1;
						root_d  = low8(p_rd);
						state_d = ST_IDLE;
					end
				end
			end
			ST_COMP: begin
				if (cur_q == root_idx_q) begin
					done_d  = 1'b1;
					root_d  = low8(root_idx_q);
					state_d = ST_IDLE;
				end else begin
					p_we  = 1'b1;
					p_wa  = cur_q;
					p_wd  = root_idx_q;
					cur_d = p_rd;
					p_ra  = p_rd;
				end
			end
			ST_URA: begin
				ra_d    = r_rd;
				r_ra    = b_q;
				state_d = ST_URB;
			end
			ST_URB: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				p_we    = 1'b1;
				if (ra_q > r_rd) begin
					p_wa   = b_q;
					p_wd   = a_q;
					root_d = low8(a_q);
				end else begin
					p_wa   = a_q;
					p_wd   = b_q;
					root_d = low8(b_q);
					if (ra_q == r_rd && r_rd < RANK_MAX) begin
						r_we = 1'b1;
						r_wa = b_q;
						r_wd = r_rd + 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign root      = root_q;
	assign was_union = wu_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result beat outside idle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !p_we && !r_we)
		else $error("table write while idle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> {1'b0, step_q} <= (SW + 1)'(NODES))
		else $error("walk step count beyond bound");

	a_comp_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && p_we) |-> p_wa != root_idx_q)
		else $error("compression rewrote the root");

	a_union_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_URA |=> state_q == ST_URB ##1 done)
		else $error("union did not finish in sequence");

endmodule
`default_nettype wire

// File: verif/tb_union_find_engine_unit.sv
// Self-checking testbench for the union-find engine: directed table, rank pump, random finds and unions.
`timescale 1ns / 1ps
module tb_union_find_engine_unit;
	import ufe_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DIR_ROWS = 20;
	localparam int RAND_PER_PHASE = 202;
	localparam int PUMP_BASE = 32;
	localparam int PUMP_NODES = 18;

	typedef struct packed {
		logic       op;
		logic [7:0] a;
		logic [7:0] b;
		logic       fixed;
		logic [7:0] root;
	} ufe_row_t;

	typedef struct packed {
		logic [7:0] root;
		logic       was_union;
	} ufe_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       func;
	logic [7:0] node_a;
	logic [7:0] node_b;
	logic       done;
	logic [7:0] root;
	logic       was_union;

	logic [7:0]  forest_parent [NODES_DEF];
	logic [3:0]  forest_rank [NODES_DEF];
	ufe_result_t pending_results [$];
	int          mismatches = 0;
	int          cycles = 0;

	union_find_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.done      (done),
		.root      (root),
		.was_union (was_union)
	);

	always #2 clk = ~clk;

	// walk to the root; with compress set, point the path straight at it
	function automatic logic [7:0] forest_find(logic [7:0] a, logic compress);
		logic [7:0] cur;
		logic [7:0] up;
		logic [7:0] top;
		int         steps;
		logic       hit;
		cur = a;
		steps = 0;
		hit = 1'b0;
		while (!hit && steps <= NODES_DEF) begin
			up = forest_parent[cur];
			if (up == cur) begin
				hit = 1'b1;
			end else begin
				cur = up;
				steps = steps + 1;
			end
		end
		top = cur;
		if (hit && compress) begin
			cur = a;
			while (cur != top) begin
				up = forest_parent[cur];
				forest_parent[cur] = top;
				cur = up;
			end
		end
		return top;
	endfunction

	function automatic logic [7:0] forest_apply(logic op, logic [7:0] a, logic [7:0] b);
		if (op == FUNC_FIND)
			return forest_find(a, 1'b1);
		if (a == b)
			return a;
		if (forest_rank[a] > forest_rank[b]) begin
			forest_parent[b] = a;
			return a;
		end
		forest_parent[a] = b;
		if (forest_rank[a] == forest_rank[b] && forest_rank[b] < RANK_MAX)
			forest_rank[b] = forest_rank[b] + 4'd1;
		return b;
	endfunction

	function automatic ufe_row_t directed_row(int i);
		ufe_row_t r;
		r = '0;
		case (i)
			0: r = {FUNC_FIND, 8'd0, 8'd255, 1'b1, 8'd0};
			1: r = {FUNC_FIND, 8'd255, 8'd0, 1'b1, 8'd255};
			2: r = {FUNC_UNION, 8'd0, 8'd0, 1'b1, 8'd0};
			3: r = {FUNC_UNION, 8'd255, 8'd255, 1'b1, 8'd255};
			4: r = {FUNC_UNION, 8'd0, 8'd255, 1'b1, 8'd255};
			5: r = {FUNC_FIND, 8'd0, 8'd0, 1'b1, 8'd255};
			6: r = {FUNC_UNION, 8'd1, 8'd2, 1'b1, 8'd2};
			7: r = {FUNC_UNION, 8'd2, 8'd255, 1'b0, 8'd0};
			8: r = {FUNC_FIND, 8'd1, 8'd170, 1'b0, 8'd0};
			9: r = {FUNC_FIND, 8'd1, 8'd85, 1'b0, 8'd0};
			10: r = {FUNC_UNION, 8'd10, 8'd11, 1'b1, 8'd11};
			11: r = {FUNC_UNION, 8'd12, 8'd10, 1'b1, 8'd10};
			// non-root union closes a loop 10 -> 11 -> 10
			12: r = {FUNC_UNION, 8'd11, 8'd10, 1'b0, 8'd0};
			13: r = {FUNC_FIND, 8'd12, 8'd0, 1'b0, 8'd0};
			14: r = {FUNC_FIND, 8'd10, 8'd255, 1'b0, 8'd0};
			15: r = {FUNC_UNION, 8'd128, 8'd127, 1'b1, 8'd127};
			16: r = {FUNC_FIND, 8'd128, 8'd0, 1'b1, 8'd127};
			17: r = {FUNC_UNION, 8'd85, 8'd170, 1'b1, 8'd170};
			18: r = {FUNC_FIND, 8'd85, 8'd85, 1'b0, 8'd0};
			19: r = {FUNC_UNION, 8'd170, 8'd170, 1'b1, 8'd170};
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		if (mismatches < 50)
			$display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycles);
		mismatches = mismatches + 1;
	endtask

	// one beat; the expectation is taken when the engine accepts it
	task automatic send_op(logic op, logic [7:0] a, logic [7:0] b, logic fixed,
			logic [7:0] fixed_root);
		ufe_result_t res;
		start <= 1'b1;
		func <= op;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res.root = forest_apply(op, a, b);
		res.was_union = op;
		if (fixed)
			res.root = fixed_root;
		pending_results.push_back(res);
	endtask

	task automatic idle_gap(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			func <= 1'($urandom_range(1));
			node_a <= 8'($urandom_range(255));
			node_b <= 8'($urandom_range(255));
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_node();
		if ($urandom_range(1))
			return 8'($urandom_range(15));
		return 8'($urandom_range(255));
	endfunction

	task automatic random_op();
		logic [7:0] a;
		logic [7:0] b;
		int         pick;
		a = pick_node();
		b = pick_node();
		pick = $urandom_range(99);
		if (pick < 45)
			send_op(FUNC_FIND, a, 8'($urandom_range(255)), 1'b0, 8'd0);
		else if (pick < 85)
			send_op(FUNC_UNION, forest_find(a, 1'b0), forest_find(b, 1'b0), 1'b0, 8'd0);
		else if (pick < 95)
			send_op(FUNC_UNION, a, b, 1'b0, 8'd0);
		else
			send_op(FUNC_UNION, a, a, 1'b0, 8'd0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("result with nothing pending, root", root, 8'd0);
			end else begin
				if (root !== pending_results[0].root)
					report("root", root, pending_results[0].root);
				if (was_union !== pending_results[0].was_union)
					report("was_union", {7'd0, was_union}, {7'd0, pending_results[0].was_union});
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		ufe_row_t row;
		int       pct;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_FIND;
		node_a = 8'd0;
		node_b = 8'd0;
		for (int n = 0; n < NODES_DEF; n++) begin
			forest_parent[n] = 8'(n);
			forest_rank[n] = 4'd0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			idle_gap(23);
			row = directed_row(i);
			send_op(row.op, row.a, row.b, row.fixed, row.root);
		end

		// node k is raised once by each lower node, so its rank climbs to k and saturates
		for (int k = 1; k < PUMP_NODES; k++)
			for (int j = 0; j < k; j++) begin
				idle_gap(23);
				send_op(FUNC_UNION, 8'(PUMP_BASE + j), 8'(PUMP_BASE + k), 1'b0, 8'd0);
			end
		send_op(FUNC_UNION, 8'(PUMP_BASE + PUMP_NODES - 1), 8'(PUMP_BASE + PUMP_NODES - 2),
			1'b0, 8'd0);

		for (int phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 23 : (phase == 1) ? 65 : 0;
			drain();
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				idle_gap(pct);
				random_op();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
